// ===== rtl/lcc_pkg.sv =====
// Shared constants, types and helpers for the LRU chunk cache lookup.
`timescale 1ns / 1ps

package lcc_pkg;

    // Cache geometry.
    localparam int NUM_SLOTS     = 16;
    localparam int CHUNK_BYTES   = 4096;
    localparam int POSITION_BITS = 48;

    // Port field widths.
    localparam int POS_W   = 48;
    localparam int SLOT_W  = 4;

    // Derived widths. CHUNK_BYTES is a power of two, so the offset is a bit field.
    localparam int SLOT_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OFFSET_BITS = $clog2(CHUNK_BYTES);
    localparam int USED_BITS   = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
    localparam int TAG_BITS    = USED_BITS - OFFSET_BITS;
    localparam int SLOT_WIDE_W = (SLOT_BITS > SLOT_W) ? SLOT_BITS : SLOT_W;

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [TAG_BITS-1:0]  tag_t;

    // One entry of the recency list: the slot, its validity and its chunk tag.
    typedef struct packed {
        slot_t slot;
        logic  valid;
        tag_t  tag;
    } entry_t;

    // Chunk tag of a byte position: the used bits above the chunk offset.
    function automatic tag_t tag_of(input logic [POS_W-1:0] pos);
        return pos[USED_BITS-1:OFFSET_BITS];
    endfunction

    // Byte position of the chunk boundary for a tag.
    function automatic logic [POS_W-1:0] base_of(input tag_t tag);
        logic [POS_W-1:0] base;
        base = '0;
        base[USED_BITS-1:OFFSET_BITS] = tag;
        return base;
    endfunction

    // Low bits of a slot index as carried on the result port.
    function automatic logic [SLOT_W-1:0] slot_field(input slot_t slot);
        logic [SLOT_WIDE_W-1:0] wide;
        wide = '0;
        wide[SLOT_BITS-1:0] = slot;
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/lcc_cell.sv =====
// One position of the recency list: holds an entry, compares its tag, shifts on demand.
`timescale 1ns / 1ps

module lcc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcc_pkg::slot_t        reset_slot,
    input  logic                  shift_en,
    input  lcc_pkg::entry_t       entry_in,
    input  lcc_pkg::tag_t         probe_tag,
    output lcc_pkg::entry_t       entry_out,
    output logic                  match
);
    import lcc_pkg::*;

    slot_t slot_reg;
    logic  valid_reg;
    tag_t  tag_reg;

    // Slot number and valid flag: identity order, all invalid after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= reset_slot;
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            slot_reg  <= entry_in.slot;
            valid_reg <= entry_in.valid;
        end
    end

    // Tag storage; only meaningful once the entry is valid.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tag_reg <= entry_in.tag;
        end
    end

    // Local tag compare against the incoming chunk.
    assign match = valid_reg && (tag_reg == probe_tag);

    assign entry_out.slot  = slot_reg;
    assign entry_out.valid = valid_reg;
    assign entry_out.tag   = tag_reg;

endmodule

// ===== rtl/lru_chunk_cache_lookup.sv =====
// Top level of the fully associative chunk cache tag lookup with true LRU order.
`timescale 1ns / 1ps
//
//  Channel  | Handshake                 | Fields
//  ---------+---------------------------+----------------------------------------
//  input    | in_valid / in_ready       | byte_position[47:0]
//  result   | out_valid / out_ready     | slot_number[3:0], was_hit, aligned_base[47:0]
//
// Each word is looked up and the recency list updated in the cycle it is accepted;
// its result appears in the output register on the next cycle.
// One word per cycle is sustained while results are taken; the parallel tag compare
// across the cell row and the one-step shift of the row set that figure.
// After reset all slots are invalid and the list holds slot i at position i.
// A result that is not taken holds the output register and stops new input words.

module lru_chunk_cache_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lcc_pkg::POS_W-1:0]     byte_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lcc_pkg::SLOT_W-1:0]    slot_number,
    output logic                          was_hit,
    output logic [lcc_pkg::POS_W-1:0]     aligned_base
);
    import lcc_pkg::*;

    tag_t                     probe_tag;
    logic                     accept;
    logic [NUM_SLOTS-1:0]     match;
    logic [NUM_SLOTS-1:0]     shift_en;
    entry_t                   cell_out [NUM_SLOTS];
    entry_t                   cell_in  [NUM_SLOTS];
    entry_t                   front;
    logic                     hit;
    slot_t                    hit_slot;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [SLOT_W-1:0]        slot_number_reg;
    logic                     was_hit_reg;
    logic [POS_W-1:0]         aligned_base_reg;

    assign probe_tag = tag_of(byte_position);
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign hit       = |match;

    // Slot of the matching cell; valid slots never share a tag, so at most one matches.
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            hit_slot = hit_slot | (match[i] ? cell_out[i].slot : slot_t'(0));
        end
    end

    // Entry that moves to the front: the hit entry, or the oldest one retagged.
    always_comb
    begin
        front.slot  = hit ? hit_slot : cell_out[NUM_SLOTS-1].slot;
        front.valid = 1'b1;
        front.tag   = probe_tag;
    end

    // A cell shifts when the promoted entry sits at its position or behind it.
    always_comb
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            shift_en[k] = accept && (!hit || (|(match >> k)));
        end
    end

    // Row of cells, each fed by its neighbor toward the front.
    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_in[g] = front;
            end
            else
            begin : g_body
                assign cell_in[g] = cell_out[g-1];
            end

            lcc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .reset_slot (slot_t'(g)),
                .shift_en   (shift_en[g]),
                .entry_in   (cell_in[g]),
                .probe_tag  (probe_tag),
                .entry_out  (cell_out[g]),
                .match      (match[g])
            );
        end
    endgenerate

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word payload, loaded on each accepted input word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_number_reg  <= slot_field(front.slot);
            was_hit_reg      <= hit;
            aligned_base_reg <= base_of(probe_tag);
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_number  = slot_number_reg;
    assign was_hit      = was_hit_reg;
    assign aligned_base = aligned_base_reg;

endmodule

// ===== bench/tb_lru_chunk_cache_lookup.sv =====
// Self-checking testbench for the LRU chunk cache lookup: directed and random words.
`timescale 1ns / 1ps

module tb_lru_chunk_cache_lookup;

    import lcc_pkg::*;

    // Address masks used by the lookup predictor.
    localparam logic [POS_W-1:0] USED_MASK   = {POS_W{1'b1}} >> (POS_W - USED_BITS);
    localparam logic [POS_W-1:0] OFFSET_MASK = POS_W'(CHUNK_BYTES - 1);
    localparam int               QUIET_LIMIT = 2000;
    localparam int               WORD_TARGET = 700;
    localparam int               POOL_DEPTH  = 24;
    localparam int               HOLD_AFTER  = 200;
    localparam int               HOLD_CYCLES = 250;

    // Stimulus flavors for the random phases.
    typedef enum int {
        MIX_HOT,
        MIX_THRASH,
        MIX_WALK,
        MIX_NOISE
    } access_mix_e;

    // Receiver stall patterns.
    typedef enum int {
        TAKE_ALWAYS,
        TAKE_HALF,
        TAKE_RARE,
        TAKE_TOGGLE
    } take_mode_e;

    // One expected lookup result.
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic [POS_W-1:0]  base;
    } lookup_result_t;

    // Tag store and recency list predictor plus the queue of expected results.
    class chunk_lookup_board;
        logic [POS_W-1:0] held_base[NUM_SLOTS];
        bit               slot_live[NUM_SLOTS];
        int               lru_list[NUM_SLOTS];
        lookup_result_t   pending_lookups[$];
        int               errors;
        int               checked;
        int               hits;
        int               misses;
        int               evictions;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                held_base[i] = '0;
                slot_live[i] = 1'b0;
                lru_list[i]  = i;
            end
            errors    = 0;
            checked   = 0;
            hits      = 0;
            misses    = 0;
            evictions = 0;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        // Predict the lookup for an accepted word and queue its result.
        function void note_access(logic [POS_W-1:0] pos);
            lookup_result_t   want;
            logic [POS_W-1:0] base;
            int               at;
            int               slot;
            base = pos & USED_MASK & ~OFFSET_MASK;
            at   = -1;
            // Search from most to least recent; valid bases are unique.
            for (int p = 0; p < NUM_SLOTS; p++)
            begin
                if (at < 0 && slot_live[lru_list[p]] && held_base[lru_list[p]] == base)
                    at = p;
            end
            want.hit = (at >= 0);
            if (at < 0)
            begin
                at = NUM_SLOTS - 1;
                misses++;
                if (slot_live[lru_list[at]])
                    evictions++;
            end
            else
            begin
                hits++;
            end
            // Move the chosen slot to the front of the list.
            slot = lru_list[at];
            for (int p = at; p > 0; p--)
                lru_list[p] = lru_list[p - 1];
            lru_list[0] = slot;
            if (!want.hit)
            begin
                held_base[slot] = base;
                slot_live[slot] = 1'b1;
            end
            want.slot = SLOT_W'(slot);
            want.base = base;
            pending_lookups.push_back(want);
        endfunction

        task report_mismatch(string what);
            if (errors < 30)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        // Compare a taken result word with the oldest expectation.
        task check_lookup(logic [SLOT_W-1:0] slot, logic hit, logic [POS_W-1:0] base);
            lookup_result_t want;
            checked++;
            if (pending_lookups.size() == 0)
            begin
                report_mismatch("result word with no lookup outstanding");
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot_number %0h, expected %0h", slot, want.slot));
                if (hit !== want.hit)
                    report_mismatch($sformatf("was_hit %0b, expected %0b", hit, want.hit));
                if (base !== want.base)
                    report_mismatch($sformatf("aligned_base %h, expected %h", base, want.base));
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [POS_W-1:0]  byte_position;
    logic              out_valid;
    logic              out_ready;
    logic [SLOT_W-1:0] slot_number;
    logic              was_hit;
    logic [POS_W-1:0]  aligned_base;

    chunk_lookup_board board;
    logic [POS_W-1:0]  chunk_pool[POOL_DEPTH];
    int                words_sent;
    int                quiet_cycles;
    bit                long_hold_done;

    lru_chunk_cache_lookup i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_position (byte_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot_number   (slot_number),
        .was_hit       (was_hit),
        .aligned_base  (aligned_base)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [POS_W-1:0] random_position();
        logic [POS_W-1:0] r;
        r[31:0]      = $urandom;
        r[POS_W-1:32] = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    // Offer one word and hold it until the block accepts it.
    task send_word(logic [POS_W-1:0] pos);
        in_valid      <= 1'b1;
        byte_position <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_access(pos);
        words_sent++;
    endtask

    task idle_input(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Check every result word the block hands over, and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready)
                board.check_lookup(slot_number, was_hit, aligned_base);
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: stall patterns of random length, plus one long hold-off.
    initial
    begin
        take_mode_e mode;
        int         seg_left;
        int         phase;
        out_ready      = 1'b0;
        long_hold_done = 1'b0;
        mode           = TAKE_ALWAYS;
        seg_left       = 0;
        phase          = 0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && board.checked >= HOLD_AFTER)
            begin
                // Let the output register fill and back up the input side.
                out_ready      <= 1'b0;
                long_hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = take_mode_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                phase++;
                case (mode)
                    TAKE_ALWAYS: out_ready <= 1'b1;
                    TAKE_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    TAKE_RARE:   out_ready <= ($urandom_range(0, 3) == 0);
                    default:     out_ready <= phase[0];
                endcase
            end
        end
    end

    // Sender: directed words first, then random phases in bursts.
    initial
    begin
        access_mix_e      mix;
        logic [POS_W-1:0] walk_pos;
        logic [POS_W-1:0] pos;
        int               phase_left;
        int               pool_use;
        int               burst_left;
        bit               gapless;

        board         = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        byte_position = '0;
        words_sent    = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of the position, hits on the same chunk at other offsets.
        send_word(48'h0000_0000_0000);
        send_word(48'h0000_0000_0FFF);
        send_word(48'hFFFF_FFFF_FFFF);
        send_word(48'hFFFF_FFFF_F000);
        send_word(48'h8000_0000_0000);
        send_word(48'h0000_0000_1000);
        // Fill the remaining slots with distinct chunks.
        for (int k = 2; k < 14; k++)
            send_word(48'(k) * CHUNK_BYTES + 48'(k * 7));
        // All slots valid: a new chunk evicts the least recent one (chunk 0).
        send_word(48'h1000_0000_0000);
        // The evicted chunk misses again; an older chunk hits from mid-list.
        send_word(48'h0000_0000_0ABC);
        send_word(48'hFFFF_FFFF_F123);
        send_word(48'h0000_0000_5555);

        // Random phases with different working sets and sender gap habits.
        walk_pos = random_position();
        while (words_sent < WORD_TARGET)
        begin
            mix        = access_mix_e'($urandom_range(0, 3));
            phase_left = $urandom_range(40, 100);
            gapless    = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 30);
            pool_use   = (mix == MIX_HOT) ? $urandom_range(4, 14)
                                          : $urandom_range(17, POOL_DEPTH);
            for (int i = 0; i < POOL_DEPTH; i++)
                chunk_pool[i] = random_position() & ~OFFSET_MASK;
            while (phase_left > 0 && words_sent < WORD_TARGET)
            begin
                case (mix)
                    MIX_HOT, MIX_THRASH:
                        pos = chunk_pool[$urandom_range(0, pool_use - 1)]
                              | (random_position() & OFFSET_MASK);
                    MIX_WALK:
                    begin
                        walk_pos = walk_pos + $urandom_range(1, 3000);
                        pos      = walk_pos;
                    end
                    default:
                        pos = random_position();
                endcase
                send_word(pos);
                phase_left--;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    if (!gapless)
                        idle_input($urandom_range(1, 8));
                end
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding lookups, then watch for stray result words.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d lookups: %0d hits, %0d misses, %0d of them evicting a valid slot.",
                 words_sent, board.hits, board.misses, board.evictions);
        $display("Results were held off once for %0d cycles to back up the input side.",
                 HOLD_CYCLES);
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
